// ===== hw/rtl/kdic_pkg.sv =====
package kdic_pkg;

  localparam int unsigned KeyCodeW = 10;
  localparam int unsigned CountW   = 4;
  localparam int unsigned ValueW   = 34;
  localparam int unsigned IdW      = 32;
  localparam int unsigned DigitW   = 4;

  typedef logic [KeyCodeW-1:0] key_code_t;
  typedef logic [CountW-1:0]   digit_count_t;
  typedef logic [ValueW-1:0]   digit_value_t;
  typedef logic [IdW-1:0]      id_number_t;
  typedef logic [DigitW-1:0]   digit_t;

  localparam key_code_t KeyEsc   = 10'd1;
  localparam key_code_t KeyOne   = 10'd2;
  localparam key_code_t KeyZero  = 10'd11;
  localparam key_code_t KeyEnter = 10'd28;

  localparam int unsigned  MaxDigitsDefault = 10;
  localparam digit_count_t MinDigitsReset   = 4'd4;

  // Digit keys 1..9 map to codes 2..10, digit 0 to code 11.
  function automatic digit_t key_digit(key_code_t code);
    digit_t d;
    if (code == KeyZero) begin
      d = '0;
    end else begin
      d = DigitW'(code - KeyOne + 10'd1);
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/kdic_if.sv =====
interface kdic_key_if;
  import kdic_pkg::*;

  logic      valid;
  logic      ready;
  logic      key_down;
  key_code_t key_code;

  modport source (output valid, output key_down, output key_code, input ready);
  modport sink   (input valid, input key_down, input key_code, output ready);
endinterface

interface kdic_id_if;
  import kdic_pkg::*;

  logic       valid;
  logic       ready;
  id_number_t id_number;

  modport source (output valid, output id_number, input ready);
  modport sink   (input valid, input id_number, output ready);
endinterface

// ===== hw/rtl/keypad_decimal_id_collector.sv =====
// Channel   Dir  Handshake     Payload
// key_i     in   valid/ready   key_down[0:0], key_code[9:0]
// id_o      out  valid/ready   id_number[31:0]
// cfg       in   cfg_we_i      cfg_wdata_i[3:0] = min_digits
//
// One key transaction per cycle while ready; entry state updates at the accepting edge.
// A result shows on id_o the cycle after the ENTER transaction, from the output register.
// key_i.ready drops only while that register holds a result that id_o has not taken.
// rst_ni clears the entry, the error flag and the output valid; min_digits resets to 4.
module keypad_decimal_id_collector #(
  parameter int unsigned MaxDigits = kdic_pkg::MaxDigitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [kdic_pkg::CountW-1:0]  cfg_wdata_i,
  kdic_key_if.sink                     key_i,
  kdic_id_if.source                    id_o
);
  import kdic_pkg::*;

  localparam digit_count_t MaxCount = CountW'(MaxDigits);

  digit_value_t value_q, value_d;
  digit_count_t count_q, count_d;
  logic         err_q, err_d;
  digit_count_t min_digits_q;
  logic         id_valid_q, id_valid_d;
  id_number_t   id_number_q;

  logic         accept;
  logic         is_digit;
  logic         is_esc;
  logic         is_enter;
  logic         emit;
  digit_value_t value_x10;
  id_number_t   id_sat;

  assign key_i.ready = !id_valid_q || id_o.ready;
  assign accept      = key_i.valid && key_i.ready;

  assign is_digit  = (key_i.key_code >= KeyOne) && (key_i.key_code <= KeyZero);
  assign is_esc    = (key_i.key_code == KeyEsc);
  assign is_enter  = (key_i.key_code == KeyEnter);
  assign value_x10 = {value_q[ValueW-4:0], 3'b000} + {value_q[ValueW-2:0], 1'b0};
  assign id_sat    = (value_q[ValueW-1:IdW] != '0) ? '1 : value_q[IdW-1:0];

  always_comb begin
    value_d = value_q;
    count_d = count_q;
    err_d   = err_q;
    emit    = 1'b0;
    if (accept && key_i.key_down) begin
      if (err_q) begin
        if (is_enter || is_esc) begin
          err_d   = 1'b0;
          value_d = '0;
          count_d = '0;
        end
      end else if (is_digit) begin
        if (count_q >= MaxCount) begin
          err_d = 1'b1;
        end else begin
          value_d = value_x10 + ValueW'(key_digit(key_i.key_code));
          count_d = count_q + 4'd1;
        end
      end else if (is_esc) begin
        value_d = '0;
        count_d = '0;
      end else if (is_enter) begin
        value_d = '0;
        count_d = '0;
        emit    = (count_q >= min_digits_q);
      end
    end
  end

  assign id_valid_d = emit || (id_valid_q && !id_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q      <= '0;
      count_q      <= '0;
      err_q        <= 1'b0;
      min_digits_q <= MinDigitsReset;
      id_valid_q   <= 1'b0;
    end else begin
      value_q    <= value_d;
      count_q    <= count_d;
      err_q      <= err_d;
      id_valid_q <= id_valid_d;
      if (cfg_we_i) begin
        min_digits_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      id_number_q <= id_sat;
    end
  end

  assign id_o.valid     = id_valid_q;
  assign id_o.id_number = id_number_q;

endmodule

// ===== hw/rtl/kdic_checker.sv =====
module kdic_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic key_valid_i,
  input logic key_ready_i,
  input logic key_down_i,
  input logic id_valid_i,
  input logic id_ready_i
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_valid_i && !id_ready_i |=> id_valid_i)
    else $error("id transaction dropped while stalled");

  // output register empty means input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !id_valid_i |-> key_ready_i)
    else $error("key_i stalled with empty output");

  // a fresh result needs a key transaction on the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    id_valid_i && !$past(id_valid_i && !id_ready_i)
      |-> $past(key_valid_i && key_ready_i && key_down_i))
    else $error("result without a key press");

  // a non-press event never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_valid_i && key_ready_i && !key_down_i |=> !id_valid_i)
    else $error("result from a non-press event");

endmodule

bind keypad_decimal_id_collector kdic_checker u_kdic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .key_valid_i (key_i.valid),
  .key_ready_i (key_i.ready),
  .key_down_i  (key_i.key_down),
  .id_valid_i  (id_o.valid),
  .id_ready_i  (id_o.ready)
);
